FILE: rtl/crcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_pkg
// Shared types, constants and the CRC-16/XMODEM byte update for the framer.
// ----------------------------------------------------------------------------
package crcf_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned CrcW         = 16;
  localparam int unsigned CntW         = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned StepW        = 5;
  localparam int unsigned DefMaxPayload = 251;
  localparam int unsigned DefQueueDepth = 4;

  localparam logic [CrcW-1:0] CrcPoly     = 16'h1021;
  localparam logic [CntW-1:0] LenOverhead = 8'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEADER_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_LOW  = 2'd1;

  // one bit per result slot of a job, in emission order
  localparam int unsigned STEP_HDR_HI = 0;
  localparam int unsigned STEP_HDR_LO = 1;
  localparam int unsigned STEP_DATA   = 2;
  localparam int unsigned STEP_CRC_HI = 3;
  localparam int unsigned STEP_CRC_LO = 4;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_CRC     = 2'd2
  } byte_kind_e;

  typedef struct packed {
    logic [StepW-1:0] steps;
    logic [ByteW-1:0] hdr_hi;
    logic [ByteW-1:0] hdr_lo;
    logic [ByteW-1:0] data;
    logic             too_long;
    logic [CrcW-1:0]  crc;
    logic [CntW-1:0]  len;
  } job_t;

  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/crcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_front
// Accepts payload requests, tracks frame state and the running CRC, and
// turns each request into one job describing the bytes it emits.
// ----------------------------------------------------------------------------
module crcf_front #(
  parameter int unsigned MAX_PAYLOAD = crcf_pkg::DefMaxPayload
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [crcf_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          accept_i,
  input  logic [crcf_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          last_i,
  input  logic                          empty_packet_i,
  output crcf_pkg::job_t                job_o
);
  import crcf_pkg::*;

  logic [ByteW-1:0] hdr_hi_q, hdr_lo_q;
  logic             in_frame_q, in_frame_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [CrcW-1:0]  crc_base, crc_new;
  logic [CntW-1:0]  cnt_base, cnt_new;
  logic             over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_hi_q <= '0;
      hdr_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_HIGH: hdr_hi_q <= cfg_data_i;
        CFG_HEADER_LOW:  hdr_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    crc_base = in_frame_q ? crc_q : '0;
    cnt_base = in_frame_q ? cnt_q : '0;
    over     = (cnt_base >= CntW'(MAX_PAYLOAD));
    cnt_new  = over ? cnt_base : cnt_base + 1'b1;
    crc_new  = crc_fold(crc_base, data_byte_i);

    job_o        = '0;
    job_o.hdr_hi = hdr_hi_q;
    job_o.hdr_lo = hdr_lo_q;
    job_o.data   = data_byte_i;
    job_o.steps[STEP_HDR_HI] = !in_frame_q;
    job_o.steps[STEP_HDR_LO] = !in_frame_q;

    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;

    if (empty_packet_i) begin
      // close whatever frame is open, or a fresh empty one
      job_o.steps[STEP_CRC_HI] = 1'b1;
      job_o.steps[STEP_CRC_LO] = 1'b1;
      job_o.crc = crc_base;
      job_o.len = cnt_base + LenOverhead;
      in_frame_d = 1'b0;
      crc_d      = '0;
      cnt_d      = '0;
    end else begin
      job_o.steps[STEP_DATA]   = 1'b1;
      job_o.steps[STEP_CRC_HI] = last_i;
      job_o.steps[STEP_CRC_LO] = last_i;
      job_o.too_long = over;
      job_o.crc      = crc_new;
      job_o.len      = cnt_new + LenOverhead;
      in_frame_d = !last_i;
      crc_d      = last_i ? '0 : crc_new;
      cnt_d      = last_i ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= '0;
      cnt_q      <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

FILE: rtl/crcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_queue
// Small job FIFO between the front and back halves of the framer.
// ----------------------------------------------------------------------------
module crcf_queue #(
  parameter int unsigned DEPTH = crcf_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crcf_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output crcf_pkg::job_t head_job_o
);
  import crcf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntQW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CntQW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/crcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcf_back
// Walks the result slots of the head job and emits one frame byte per
// cycle into the output register while a head job is valid and the output is not stalled.
// ----------------------------------------------------------------------------
module crcf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  crcf_pkg::job_t             head_job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [crcf_pkg::ByteW-1:0] out_byte_o,
  output crcf_pkg::byte_kind_e       byte_kind_o,
  output logic                       frame_end_o,
  output logic [crcf_pkg::CntW-1:0]  frame_length_o,
  output logic                       too_long_o
);
  import crcf_pkg::*;

  logic [StepW-1:0] done_q, done_d;
  logic [StepW-1:0] pending, pick, rest;
  logic             load;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  byte_kind_e       kind_q, kind_d;
  logic             end_q, end_d;
  logic [CntW-1:0]  len_q, len_d;
  logic             tl_q, tl_d;

  always_comb begin
    pending = head_job_i.steps & ~done_q;
    pick    = pending & (~pending + 1'b1);
    rest    = pending & ~pick;
    load    = head_valid_i && (!out_valid_q || !out_stall_i);
    pop_o   = load && (rest == '0);

    done_d = done_q;
    if (load) begin
      done_d = (rest == '0) ? '0 : (done_q | pick);
    end

    byte_d = head_job_i.data;
    kind_d = KIND_PAYLOAD;
    end_d  = 1'b0;
    len_d  = '0;
    tl_d   = 1'b0;
    if (pick[STEP_HDR_HI]) begin
      byte_d = head_job_i.hdr_hi;
      kind_d = KIND_HEADER;
    end else if (pick[STEP_HDR_LO]) begin
      byte_d = head_job_i.hdr_lo;
      kind_d = KIND_HEADER;
    end else if (pick[STEP_DATA]) begin
      tl_d = head_job_i.too_long;
    end else if (pick[STEP_CRC_HI]) begin
      byte_d = head_job_i.crc[CrcW-1:ByteW];
      kind_d = KIND_CRC;
    end else begin
      byte_d = head_job_i.crc[ByteW-1:0];
      kind_d = KIND_CRC;
      end_d  = 1'b1;
      len_d  = head_job_i.len;
    end

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      end_q  <= end_d;
      len_q  <= len_d;
      tl_q   <= tl_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign byte_kind_o    = kind_q;
  assign frame_end_o    = end_q;
  assign frame_length_o = len_q;
  assign too_long_o     = tl_q;

`ifndef SYNTHESIS
  a_end_is_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && end_q) |-> (kind_q == KIND_CRC))
    else $error("frame end on a non-CRC byte");

  a_len_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !end_q) |-> (len_q == '0))
    else $error("frame length outside closing byte");

  a_too_long_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tl_q) |-> (kind_q == KIND_PAYLOAD))
    else $error("too_long on a non-payload byte");

  a_done_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ((done_q & ~head_job_i.steps) == '0))
    else $error("completed slot not in head job");
`endif

endmodule

FILE: rtl/crc16_packet_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_framer_core
// Frames payload bytes with a two-byte header and a trailing CRC-16/XMODEM.
// ----------------------------------------------------------------------------
// With an empty queue, an accepted request is first written into the job
// queue and its first result is then registered in the output register.
// Throughput: one request per cycle while the job queue (QUEUE_DEPTH) has
// room; the output emits one result per cycle while out_stall_i is low, so a
// request with n results holds the output until all n are taken.
// Reset: clears header registers, frame state, CRC, count, queue and output.
module crc16_packet_framer_core #(
  parameter int unsigned MAX_PAYLOAD = crcf_pkg::DefMaxPayload,
  parameter int unsigned QUEUE_DEPTH = crcf_pkg::DefQueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crcf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [crcf_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [crcf_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         last_i,
  input  logic                         empty_packet_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [crcf_pkg::ByteW-1:0]   out_byte_o,
  output crcf_pkg::byte_kind_e         byte_kind_o,
  output logic                         frame_end_o,
  output logic [crcf_pkg::CntW-1:0]    frame_length_o,
  output logic                         too_long_o
);
  import crcf_pkg::*;

  job_t new_job, head_job;
  logic full, accept, head_valid, pop;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  crcf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .empty_packet_i(empty_packet_i),
    .job_o         (new_job)
  );

  crcf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_job_i  (new_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_job_o  (head_job)
  );

  crcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_job_i    (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_kind_o   (byte_kind_o),
    .frame_end_o   (frame_end_o),
    .frame_length_o(frame_length_o),
    .too_long_o    (too_long_o)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks crc16_packet_framer_core against a cycle-free model of the framing:
// header bytes, payload pass-through, CRC-16/XMODEM trailer, frame length and
// the too-long flag. Requests are driven with random gaps, results are taken
// with random stalls, and the header registers change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import crcf_pkg::*;

  localparam int unsigned MaxPayload = DefMaxPayload;

  // indexes past the two header registers; writes to them are dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] value;
    byte_kind_e       kind;
    logic             frame_end;
    logic [CntW-1:0]  frame_length;
    logic             too_long;
  } frame_byte_t;

  class framer_scoreboard;
    logic [ByteW-1:0] hdr_hi;
    logic [ByteW-1:0] hdr_lo;
    logic [CrcW-1:0]  crc;
    logic             frame_open;
    int unsigned      payload_bytes;
    int unsigned      errors;
    frame_byte_t      pending[$];

    function new();
      hdr_hi        = '0;
      hdr_lo        = '0;
      crc           = '0;
      frame_open    = 1'b0;
      payload_bytes = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CFG_HEADER_HIGH: hdr_hi = val;
        CFG_HEADER_LOW:  hdr_lo = val;
        default: ;
      endcase
    endfunction

    // shift the byte in MSB first, feedback into polynomial 0x1021
    function logic [CrcW-1:0] crc_xmodem_step(logic [CrcW-1:0] acc, logic [ByteW-1:0] b);
      logic [CrcW-1:0] r;
      logic            fb;
      r = acc;
      for (int i = ByteW - 1; i >= 0; i--) begin
        fb = r[CrcW-1] ^ b[i];
        r  = {r[CrcW-2:0], 1'b0};
        if (fb) begin
          r = r ^ 16'h1021;
        end
      end
      return r;
    endfunction

    function void push(logic [ByteW-1:0] v, byte_kind_e k, logic fe, logic [CntW-1:0] len,
                       logic tl);
      frame_byte_t e;
      e.value        = v;
      e.kind         = k;
      e.frame_end    = fe;
      e.frame_length = len;
      e.too_long     = tl;
      pending.push_back(e);
    endfunction

    function void start_frame();
      push(hdr_hi, KIND_HEADER, 1'b0, '0, 1'b0);
      push(hdr_lo, KIND_HEADER, 1'b0, '0, 1'b0);
      frame_open    = 1'b1;
      crc           = '0;
      payload_bytes = 0;
    endfunction

    function void finish_frame();
      int unsigned len;
      len = payload_bytes + 4;
      if (len > 255) begin
        len = 255;
      end
      push(crc[15:8], KIND_CRC, 1'b0, '0, 1'b0);
      push(crc[7:0], KIND_CRC, 1'b1, len[CntW-1:0], 1'b0);
      frame_open    = 1'b0;
      crc           = '0;
      payload_bytes = 0;
    endfunction

    function void note_request(logic [ByteW-1:0] b, logic is_last, logic is_empty);
      logic tl;
      if (!frame_open) begin
        start_frame();
      end
      if (is_empty) begin
        finish_frame();
        return;
      end
      tl = 1'b0;
      if (payload_bytes >= MaxPayload) begin
        tl = 1'b1;
      end else begin
        payload_bytes++;
      end
      crc = crc_xmodem_step(crc, b);
      push(b, KIND_PAYLOAD, 1'b0, '0, tl);
      if (is_last) begin
        finish_frame();
      end
    endfunction

    function void check_result(frame_byte_t got);
      frame_byte_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected frame byte: got byte %02h kind %0d end %0b len %0d tl %0b",
                 $time, got.value, got.kind, got.frame_end, got.frame_length, got.too_long);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        errors++;
        $display("%0t out_byte mismatch: expected %02h actual %02h",
                 $time, want.value, got.value);
      end
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t byte_kind mismatch: expected %0d actual %0d",
                 $time, want.kind, got.kind);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t frame_end mismatch: expected %0b actual %0b",
                 $time, want.frame_end, got.frame_end);
      end
      if (got.frame_length !== want.frame_length) begin
        errors++;
        $display("%0t frame_length mismatch: expected %0d actual %0d",
                 $time, want.frame_length, got.frame_length);
      end
      if (got.too_long !== want.too_long) begin
        errors++;
        $display("%0t too_long mismatch: expected %0b actual %0b",
                 $time, want.too_long, got.too_long);
      end
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [ByteW-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ByteW-1:0]     data_byte_i;
  logic                 last_i;
  logic                 empty_packet_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ByteW-1:0]     out_byte_o;
  byte_kind_e           byte_kind_o;
  logic                 frame_end_o;
  logic [CntW-1:0]      frame_length_o;
  logic                 too_long_o;

  framer_scoreboard sb = new();
  bit               calm;
  int unsigned      rx_hold;

  crc16_packet_framer_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_request(data_byte_i, last_i, empty_packet_i);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    frame_byte_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.value        = out_byte_o;
      got.kind         = byte_kind_o;
      got.frame_end    = frame_end_o;
      got.frame_length = frame_length_o;
      got.too_long     = too_long_o;
      sb.check_result(got);
    end
  end

  // after a taken byte, sometimes stall the output before the next, except in calm phases
  always @(posedge clk_i) begin : rx_pacing
    int unsigned w;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) begin
        out_stall_i <= 1'b0;
      end
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      w = calm ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        rx_hold     <= w;
      end
    end
  end

  task automatic send_request(logic [ByteW-1:0] b, logic is_last, logic is_empty);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    last_i         <= is_last;
    empty_packet_i <= is_empty;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.idle()) @(posedge clk_i);
  endtask

  task automatic program_headers(logic [ByteW-1:0] hi, logic [ByteW-1:0] lo,
                                 logic [CfgIdxW-1:0] spare_idx, logic [ByteW-1:0] spare_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HEADER_HIGH;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    sb.write_reg(CFG_HEADER_HIGH, hi);
    cfg_index_i <= CFG_HEADER_LOW;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    sb.write_reg(CFG_HEADER_LOW, lo);
    cfg_index_i <= spare_idx;
    cfg_data_i  <= spare_val;
    @(posedge clk_i);
    sb.write_reg(spare_idx, spare_val);
    cfg_we_i <= 1'b0;
  endtask

  // one payload run; close it with last or, now and then, with an empty request
  task automatic send_frame(int unsigned n_bytes);
    bit close_by_empty;
    close_by_empty = ($urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      send_request(ByteW'($urandom_range(0, 255)), (i == n_bytes - 1) && !close_by_empty,
                   1'b0);
    end
    if (close_by_empty) begin
      send_request(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_request(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else if (pick < 4) begin
        // broken run: bytes without a last flag, left open for the next frame
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) begin
          send_request(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        sent += n;
      end else begin
        n = (pick == 19) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_frame(n);
        sent += n;
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    last_i         = 1'b0;
    empty_packet_i = 1'b0;
    out_stall_i    = 1'b0;
    rx_hold        = 0;
    calm           = 1'b0;
    #3_000_000;
    $display("FAIL crc16_packet_framer_core");
    $finish;
  end

  initial begin : stimulus
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset headers: empty frames, single-byte extremes, an empty closing an open frame
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h31, 1'b0, 1'b0);
    send_request(8'h32, 1'b0, 1'b0);
    send_request(8'h33, 1'b1, 1'b0);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    settle();

    program_headers(8'hFF, 8'h00, CFG_SPARE_A, 8'hFF);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'hA5, 1'b1, 1'b1);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase % 3 == 1);
      case (phase)
        0: begin hi = 8'h00; lo = 8'hFF; end
        1: begin hi = 8'hFF; lo = 8'hFF; end
        2: begin hi = 8'h00; lo = 8'h00; end
        default: begin
          hi = ByteW'($urandom_range(0, 255));
          lo = ByteW'($urandom_range(0, 255));
        end
      endcase
      program_headers(hi, lo, phase[0] ? CFG_SPARE_B : CFG_SPARE_A,
                      ByteW'($urandom_range(0, 255)));
      if (phase == 2) begin
        // run past the payload limit: count saturates, later bytes flag too_long
        send_frame(MaxPayload + 2);
      end else begin
        random_traffic(36);
      end
      settle();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.idle()) begin
      $display("PASS crc16_packet_framer_core");
    end else begin
      $display("FAIL crc16_packet_framer_core");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/crcf_pkg.sv
rtl/crcf_front.sv
rtl/crcf_queue.sv
rtl/crcf_back.sv
rtl/crc16_packet_framer_core.sv
sim/testbench.sv
